### sv/dpsp_pkg.sv
// shared types and constants for the delta patch stream parser
package dpsp_pkg;

	localparam int SCRATCH_BYTES_DEF = 4096;
	localparam int LEN_W = 14;
	localparam int OFF_W = 23;
	localparam int ADDR_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [7:0] OP_COPY = 8'h80;
	localparam logic [7:0] OP_LONG = 8'h40;
	localparam logic [5:0] LEN_HI_MASK = 6'h3f;
	localparam logic [6:0] ADDR_HI_MASK = 7'h7f;
	localparam logic [7:0] SRC_STORE = 8'h80;

	// register index as seen in paddr[2]
	localparam logic REG_IMAGE_BASE = 1'b0;

	typedef enum logic [1:0] {
		KIND_RAW   = 2'd0,
		KIND_STORE = 2'd1,
		KIND_FLASH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_COMMAND = 2'd0,
		PH_PARAMS  = 2'd1,
		PH_RAW     = 2'd2
	} phase_t;

	typedef struct packed {
		logic              has_result;
		kind_t             kind;
		logic [7:0]        data_byte;
		logic [ADDR_W-1:0] source_address;
		logic [LEN_W-1:0]  copy_length;
		logic              overflow;
	} result_t;

endpackage

### sv/dpsp_apb_regs.sv
// configuration register file behind the apb port
module dpsp_apb_regs import dpsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [ADDR_W-1:0]  image_base
);

	logic [ADDR_W-1:0] image_base_q;
	logic              sel_base;

	// low address bits are ignored; only paddr[2] selects the register
	assign sel_base = (paddr[2] == REG_IMAGE_BASE) && (paddr[1:0] == 2'b00 || 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q <= '0;
		end else if (psel && penable && pwrite && sel_base) begin
			image_base_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = sel_base ? image_base_q : 32'h0;
	assign image_base = image_base_q;

endmodule

### sv/dpsp_parser.sv
// command state and per-byte decode of the patch stream
module dpsp_parser import dpsp_pkg::*; #(
	parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEF,
	parameter int POS_W = $clog2(SCRATCH_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              func,
	input  logic [7:0]        data,
	input  logic [ADDR_W-1:0] image_base,
	output result_t           res,
	output logic [POS_W-1:0]  res_dest
);

	localparam int SUM_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
	localparam logic [POS_W-1:0] POS_END = POS_W'(SCRATCH_BYTES);
	localparam logic [SUM_W-1:0] SUM_END = SUM_W'(SCRATCH_BYTES);

	phase_t            phase_q, phase_d;
	logic [7:0]        cmd_q [4];
	logic [2:0]        coll_q, coll_d;
	logic [2:0]        exp_q, exp_d;
	logic [LEN_W-1:0]  raw_cnt_q, raw_cnt_d;
	logic [POS_W-1:0]  wpos_q, wpos_d;

	logic              is_long;
	logic [LEN_W-1:0]  cmd_len;
	logic [2:0]        coll_inc;
	logic [LEN_W-1:0]  raw_inc;
	logic [7:0]        addr_hi, addr_mid;
	logic [OFF_W-1:0]  offset;
	logic              from_store;
	logic [SUM_W-1:0]  copy_end;
	logic              copy_ovf;

	assign is_long  = (cmd_q[0] & OP_LONG) != 8'h0;
	assign cmd_len  = is_long ? {cmd_q[0][5:0] & LEN_HI_MASK, cmd_q[1]}
	                          : {8'h0, cmd_q[0][5:0] & LEN_HI_MASK};
	assign coll_inc = coll_q + 3'd1;
	assign raw_inc  = raw_cnt_q + LEN_W'(1);

	// the last address byte is the one arriving now
	assign addr_hi    = is_long ? cmd_q[2] : cmd_q[1];
	assign addr_mid   = is_long ? cmd_q[3] : cmd_q[2];
	assign offset     = {addr_hi[6:0] & ADDR_HI_MASK, addr_mid, data};
	assign from_store = (addr_hi & SRC_STORE) != 8'h0;
	assign copy_end   = SUM_W'(wpos_q) + SUM_W'(cmd_len);
	assign copy_ovf   = copy_end > SUM_END;

	always_comb begin
		phase_d   = phase_q;
		coll_d    = coll_q;
		exp_d     = exp_q;
		raw_cnt_d = raw_cnt_q;
		wpos_d    = wpos_q;
		res       = '0;
		res.kind  = KIND_RAW;
		res_dest  = wpos_q;
		if (func) begin
			wpos_d = '0;
		end else begin
			case (phase_q)
				PH_PARAMS: begin
					coll_d = coll_inc;
					if (coll_inc >= exp_q) begin
						if ((cmd_q[0] & OP_COPY) == 8'h0) begin
							phase_d   = PH_RAW;
							raw_cnt_d = '0;
						end else begin
							phase_d            = PH_COMMAND;
							res.has_result     = 1'b1;
							res.kind           = from_store ? KIND_STORE : KIND_FLASH;
							res.source_address = from_store ? ADDR_W'(offset)
							                                : image_base + ADDR_W'(offset);
							res.copy_length    = cmd_len;
							res.overflow       = copy_ovf;
							wpos_d = copy_ovf ? POS_END : copy_end[POS_W-1:0];
						end
					end
				end
				PH_RAW: begin
					res.has_result  = 1'b1;
					res.data_byte   = data;
					res.copy_length = LEN_W'(1);
					if (wpos_q < POS_END) begin
						wpos_d = wpos_q + POS_W'(1);
					end else begin
						wpos_d       = POS_END;
						res_dest     = POS_END;
						res.overflow = 1'b1;
					end
					raw_cnt_d = raw_inc;
					if (raw_inc >= cmd_len) begin
						phase_d = PH_COMMAND;
					end
				end
				default: begin
					coll_d = 3'd1;
					exp_d  = 3'd1 + (((data & OP_COPY) != 8'h0) ? 3'd3 : 3'd0)
					              + (((data & OP_LONG) != 8'h0) ? 3'd1 : 3'd0);
					if ((data & (OP_COPY | OP_LONG)) != 8'h0) begin
						phase_d = PH_PARAMS;
					end else begin
						phase_d   = PH_RAW;
						raw_cnt_d = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COMMAND;
			coll_q    <= '0;
			exp_q     <= '0;
			raw_cnt_q <= '0;
			wpos_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			coll_q    <= coll_d;
			exp_q     <= exp_d;
			raw_cnt_q <= raw_cnt_d;
			wpos_q    <= wpos_d;
		end
	end

	// command bytes hold no reset value
	always_ff @(posedge clk) begin
		if (step && !func) begin
			if (phase_q == PH_PARAMS) begin
				if (coll_q < 3'd4) begin
					cmd_q[coll_q[1:0]] <= data;
				end
			end else if (phase_q != PH_RAW) begin
				cmd_q[0] <= data;
			end
		end
	end

endmodule

### sv/delta_patch_stream_parser_core.sv
// delta patch stream parser: input register, byte decode, result register
// a taken byte is held in the input register, then its result is registered in the output register
// throughput: one transaction per cycle on each side while result_stall is low; decode is one pass of short logic
// a stalled result holds the pipe, input is still taken while the input register is free
// reset: arst_n clears the parse state, write position, image_base and both valid flags
module delta_patch_stream_parser_core import dpsp_pkg::*; #(
	parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEF,
	parameter int POS_W = $clog2(SCRATCH_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               func,
	input  logic [7:0]         data,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         kind,
	output logic [POS_W-1:0]   dest_offset,
	output logic [7:0]         data_byte,
	output logic [ADDR_W-1:0]  source_address,
	output logic [LEN_W-1:0]   copy_length,
	output logic               overflow
);

	logic [ADDR_W-1:0] image_base;
	logic              valid_s1;
	logic              func_s1;
	logic [7:0]        data_s1;
	logic              valid_s2;
	result_t           res_s2;
	logic [POS_W-1:0]  dest_s2;
	result_t           res;
	logic [POS_W-1:0]  res_dest;
	logic              advance;
	logic              take;

	dpsp_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.image_base (image_base)
	);

	dpsp_parser #(
		.SCRATCH_BYTES (SCRATCH_BYTES),
		.POS_W         (POS_W)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.func       (func_s1),
		.data       (data_s1),
		.image_base (image_base),
		.res        (res),
		.res_dest   (res_dest)
	);

	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= take;
			end
			if (advance) begin
				valid_s2 <= valid_s1 && res.has_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= func;
			data_s1 <= data;
		end
		if (advance && valid_s1) begin
			res_s2  <= res;
			dest_s2 <= res_dest;
		end
	end

	assign result_valid   = valid_s2;
	assign kind           = res_s2.kind;
	assign dest_offset    = dest_s2;
	assign data_byte      = res_s2.data_byte;
	assign source_address = res_s2.source_address;
	assign copy_length    = res_s2.copy_length;
	assign overflow       = res_s2.overflow;

endmodule
